// ===== design/rmt_pkg.sv =====
// shared types and constants for the retained message table
`timescale 1ns / 1ps

package rmt_pkg;

    localparam int ENTRIES_DEF = 16;

    localparam int CMD_W       = 2;
    localparam int SLOT_W      = 8;
    localparam int GEN_W       = 16;
    localparam int MSG_W       = 16;
    localparam int LEN_W       = 16;
    localparam int IDX_W       = 4;
    localparam int IDX_EXT_W   = 9;
    localparam int COUNT_W     = 5;
    localparam int BYTES_W     = 32;
    localparam int ALU_W       = 33;

    localparam logic [BYTES_W-1:0] BUDGET_RESET = 32'd65536;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 5'd31;

    localparam logic [CMD_W-1:0] CMD_PUT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_INDEX  = 2'd3;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [GEN_W-1:0]  gen;
        logic [MSG_W-1:0]  msg;
        logic [LEN_W-1:0]  len;
    } t_entry;

    typedef struct packed {
        logic we;
        logic set_used;
        logic clr_used;
    } t_wr_ctl;

endpackage

// ===== design/retained_message_table.sv =====
// retained message table top level: sequencer, key scan and byte accounting
`timescale 1ns / 1ps

// channel   | handshake                  | payload
// ----------+----------------------------+------------------------------------------
// input     | i_in_valid / o_in_ready    | i_cmd, topic key, message, length, flags
// result    | o_out_valid / i_out_ready  | o_ok, lookups, releases, count, bytes
// config    | i_cfg_valid / o_cfg_ready  | i_cfg_byte_budget
//
// one command at a time; put, get and remove scan every entry through the single
// memory read port, one entry a cycle, while an index read reads only its own entry
// byte checks and updates reuse one 33-bit add / subtract unit over several steps
// synchronous active-low reset clears used flags, count and byte total, reloads budget
// a result waiting on i_out_ready does not block the next transfer; only the
// final step waits for the output register to free up

module retained_message_table #(
    parameter int ENTRIES = rmt_pkg::ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rmt_pkg::BYTES_W-1:0]   i_cfg_byte_budget,
    // command
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [rmt_pkg::CMD_W-1:0]     i_cmd,
    input  logic [rmt_pkg::SLOT_W-1:0]    i_topic_slot,
    input  logic [rmt_pkg::GEN_W-1:0]     i_topic_generation,
    input  logic [rmt_pkg::MSG_W-1:0]     i_message_handle,
    input  logic [rmt_pkg::LEN_W-1:0]     i_payload_len,
    input  logic                          i_handles_valid,
    input  logic                          i_msg_acquire_ok,
    input  logic                          i_topic_acquire_ok,
    input  logic [rmt_pkg::IDX_W-1:0]     i_entry_index,
    // result
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_ok,
    output logic [rmt_pkg::MSG_W-1:0]     o_out_message,
    output logic [rmt_pkg::SLOT_W-1:0]    o_out_topic_slot,
    output logic [rmt_pkg::GEN_W-1:0]     o_out_topic_generation,
    output logic                          o_release_message_valid,
    output logic [rmt_pkg::MSG_W-1:0]     o_release_message,
    output logic                          o_release_topic_valid,
    output logic [rmt_pkg::COUNT_W-1:0]   o_entry_count,
    output logic [rmt_pkg::BYTES_W-1:0]   o_bytes_in_use
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PW = $clog2(ENTRIES + 1);

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;
    localparam logic [3:0] S_POST = 4'd2;
    localparam logic [3:0] S_CHK1 = 4'd3;
    localparam logic [3:0] S_CHK2 = 4'd4;
    localparam logic [3:0] S_CHK3 = 4'd5;
    localparam logic [3:0] S_SUB  = 4'd6;
    localparam logic [3:0] S_ADD  = 4'd7;
    localparam logic [3:0] S_IDXA = 4'd8;
    localparam logic [3:0] S_IDXB = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // captured command
    logic [rmt_pkg::CMD_W-1:0]   r_req_cmd;
    logic [rmt_pkg::SLOT_W-1:0]  r_req_slot;
    logic [rmt_pkg::GEN_W-1:0]   r_req_gen;
    logic [rmt_pkg::MSG_W-1:0]   r_req_msg;
    logic [rmt_pkg::LEN_W-1:0]   r_req_len;
    logic                        r_req_macq;
    logic                        r_req_tacq;
    logic [rmt_pkg::IDX_W-1:0]   r_req_idx;

    // scan state
    logic [PW-1:0]               r_ptr;
    logic                        r_rd_vld;
    logic [AW-1:0]               r_rd_idx;
    logic                        r_hit;
    logic [AW-1:0]               r_hit_idx;
    logic [rmt_pkg::MSG_W-1:0]   r_hit_msg;
    logic [rmt_pkg::LEN_W-1:0]   r_hit_len;
    logic                        r_free;
    logic [AW-1:0]               r_free_idx;

    // accounting
    logic [rmt_pkg::BYTES_W-1:0] r_budget;
    logic [rmt_pkg::BYTES_W-1:0] r_total;
    logic [rmt_pkg::COUNT_W-1:0] r_count;
    logic [rmt_pkg::ALU_W-1:0]   r_acc;

    // pending result fields
    logic                        r_res_ok;
    logic [rmt_pkg::MSG_W-1:0]   r_res_msg;
    logic [rmt_pkg::SLOT_W-1:0]  r_res_slot;
    logic [rmt_pkg::GEN_W-1:0]   r_res_gen;
    logic                        r_res_rmv;
    logic [rmt_pkg::MSG_W-1:0]   r_res_rm;
    logic                        r_res_rtv;

    // output register
    logic                        r_o_valid;
    logic                        r_o_ok;
    logic [rmt_pkg::MSG_W-1:0]   r_o_msg;
    logic [rmt_pkg::SLOT_W-1:0]  r_o_slot;
    logic [rmt_pkg::GEN_W-1:0]   r_o_gen;
    logic                        r_o_rmv;
    logic [rmt_pkg::MSG_W-1:0]   r_o_rm;
    logic                        r_o_rtv;
    logic [rmt_pkg::COUNT_W-1:0] r_o_count;
    logic [rmt_pkg::BYTES_W-1:0] r_o_bytes;

    // store and alu hookup
    rmt_pkg::t_wr_ctl            w_ctl;
    logic [AW-1:0]               w_waddr;
    rmt_pkg::t_entry             w_wdata;
    logic [AW-1:0]               w_raddr;
    rmt_pkg::t_entry             w_rdata;
    logic [ENTRIES-1:0]          w_used;
    logic [rmt_pkg::ALU_W-1:0]   w_alu_a;
    logic [rmt_pkg::ALU_W-1:0]   w_alu_b;
    logic                        w_alu_sub;
    logic [rmt_pkg::ALU_W-1:0]   w_alu_res;
    logic                        w_alu_neg;

    logic                        w_accept;
    logic                        w_out_free;
    logic                        w_ptr_live;
    logic                        w_match;
    logic [rmt_pkg::IDX_EXT_W-1:0] w_idx_ext;
    logic [AW-1:0]               w_idx_addr;
    logic                        w_in_idx_ok;
    logic                        w_grow;
    logic                        w_new_ok;
    logic                        w_clear;
    logic [rmt_pkg::COUNT_W-1:0] w_count_dec;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_o_valid || i_out_ready;

    assign w_ptr_live  = (r_ptr < PW'(ENTRIES));
    assign w_idx_ext   = rmt_pkg::IDX_EXT_W'(r_req_idx);
    assign w_idx_addr  = w_idx_ext[AW-1:0];
    assign w_in_idx_ok = (rmt_pkg::IDX_EXT_W'(i_entry_index) < rmt_pkg::IDX_EXT_W'(ENTRIES));

    // key compare on the entry read back in the cycle after its address went out
    assign w_match = r_rd_vld && w_used[r_rd_idx]
                     && (w_rdata.slot == r_req_slot) && (w_rdata.gen == r_req_gen);

    // in-place put that grows is checked against the budget
    assign w_grow   = (r_req_len > r_hit_len);
    // new put passes budget, finds a free entry and gets both references
    assign w_new_ok = !w_alu_neg && r_free && r_req_macq && r_req_tacq;
    // remove, or in-place put whose message acquire was refused
    assign w_clear  = (r_req_cmd == rmt_pkg::CMD_REMOVE) || !r_req_macq;

    assign w_count_dec = (r_count != '0) ? (r_count - 1'b1) : r_count;

    // alu operand select per step
    always_comb begin
        w_alu_a   = '0;
        w_alu_b   = '0;
        w_alu_sub = 1'b0;
        case (r_state)
            S_CHK1: begin
                // total + new length
                w_alu_a = rmt_pkg::ALU_W'(r_total);
                w_alu_b = rmt_pkg::ALU_W'(r_req_len);
            end
            S_CHK2: begin
                // minus the old length of the hit entry
                w_alu_a   = r_acc;
                w_alu_b   = rmt_pkg::ALU_W'(r_hit_len);
                w_alu_sub = 1'b1;
            end
            S_CHK3: begin
                // budget - projected total, negative means over budget
                w_alu_a   = rmt_pkg::ALU_W'(r_budget);
                w_alu_b   = r_acc;
                w_alu_sub = 1'b1;
            end
            S_SUB: begin
                // drop the old length unless that would underflow
                w_alu_a   = rmt_pkg::ALU_W'(r_total);
                w_alu_b   = rmt_pkg::ALU_W'(r_hit_len);
                w_alu_sub = 1'b1;
            end
            S_ADD: begin
                w_alu_a = rmt_pkg::ALU_W'(r_total);
                w_alu_b = rmt_pkg::ALU_W'(r_req_len);
            end
            default: begin
                w_alu_sub = 1'b0;
            end
        endcase
    end

    // store write and read control
    always_comb begin
        w_ctl       = '0;
        w_waddr     = r_hit_idx;
        w_wdata     = '{slot: r_req_slot, gen: r_req_gen, msg: r_req_msg, len: r_req_len};
        w_raddr     = (r_state == S_SCAN) ? r_ptr[AW-1:0] : w_idx_addr;
        case (r_state)
            S_CHK3: begin
                if (!r_hit && w_new_ok) begin
                    w_ctl.we       = 1'b1;
                    w_ctl.set_used = 1'b1;
                    w_waddr        = r_free_idx;
                end
            end
            S_SUB: begin
                w_ctl.clr_used = w_clear;
            end
            S_ADD: begin
                w_ctl.we = 1'b1;
            end
            default: begin
                w_ctl = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_cmd == rmt_pkg::CMD_INDEX) begin
                        n_state = w_in_idx_ok ? S_IDXA : S_FIN;
                    end else if ((i_cmd == rmt_pkg::CMD_PUT) && !i_handles_valid) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // last compare happens in the cycle the pointer runs out
                if (!w_ptr_live) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (r_req_cmd == rmt_pkg::CMD_PUT) begin
                    n_state = S_CHK1;
                end else if ((r_req_cmd == rmt_pkg::CMD_REMOVE) && r_hit) begin
                    n_state = S_SUB;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_CHK1: begin
                n_state = r_hit ? S_CHK2 : S_CHK3;
            end
            S_CHK2: begin
                n_state = S_CHK3;
            end
            S_CHK3: begin
                if (r_hit && !(w_grow && w_alu_neg)) begin
                    n_state = S_SUB;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SUB: begin
                n_state = w_clear ? S_FIN : S_ADD;
            end
            S_ADD: begin
                n_state = S_FIN;
            end
            S_IDXA: begin
                n_state = S_IDXB;
            end
            S_IDXB: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_budget  <= rmt_pkg::BUDGET_RESET;
            r_total   <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_budget <= i_cfg_byte_budget;
            end
            case (r_state)
                S_CHK3: begin
                    if (!r_hit && w_new_ok) begin
                        r_total <= r_acc[rmt_pkg::BYTES_W-1:0];
                        if (r_count != rmt_pkg::COUNT_MAX) begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                S_SUB: begin
                    if (!w_alu_neg) begin
                        r_total <= w_alu_res[rmt_pkg::BYTES_W-1:0];
                    end
                    if (w_clear) begin
                        r_count <= w_count_dec;
                    end
                end
                S_ADD: begin
                    // wraps like the 32-bit total it models
                    r_total <= w_alu_res[rmt_pkg::BYTES_W-1:0];
                end
                default: begin
                    r_total <= r_total;
                end
            endcase
            if ((r_state == S_FIN) && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // datapath: capture, scan, result building
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_req_cmd  <= i_cmd;
                    r_req_slot <= i_topic_slot;
                    r_req_gen  <= i_topic_generation;
                    r_req_msg  <= i_message_handle;
                    r_req_len  <= i_payload_len;
                    r_req_macq <= i_msg_acquire_ok;
                    r_req_tacq <= i_topic_acquire_ok;
                    r_req_idx  <= i_entry_index;
                    r_ptr      <= '0;
                    r_rd_vld   <= 1'b0;
                    r_hit      <= 1'b0;
                    r_free     <= 1'b0;
                    r_res_ok   <= 1'b0;
                    r_res_msg  <= '0;
                    r_res_slot <= '0;
                    r_res_gen  <= '0;
                    r_res_rmv  <= 1'b0;
                    r_res_rm   <= '0;
                    r_res_rtv  <= 1'b0;
                end
            end
            S_SCAN: begin
                r_rd_vld <= w_ptr_live;
                r_rd_idx <= r_ptr[AW-1:0];
                if (w_ptr_live) begin
                    r_ptr <= r_ptr + 1'b1;
                    // lowest free entry
                    if (!r_free && !w_used[r_ptr[AW-1:0]]) begin
                        r_free     <= 1'b1;
                        r_free_idx <= r_ptr[AW-1:0];
                    end
                end
                if (w_match && !r_hit) begin
                    r_hit      <= 1'b1;
                    r_hit_idx  <= r_rd_idx;
                    r_hit_msg  <= w_rdata.msg;
                    r_hit_len  <= w_rdata.len;
                end
            end
            S_POST: begin
                if ((r_req_cmd == rmt_pkg::CMD_GET) && r_hit) begin
                    r_res_ok  <= 1'b1;
                    r_res_msg <= r_hit_msg;
                end
                if ((r_req_cmd == rmt_pkg::CMD_REMOVE) && r_hit) begin
                    r_res_ok  <= 1'b1;
                    r_res_rmv <= 1'b1;
                    r_res_rm  <= r_hit_msg;
                    r_res_rtv <= 1'b1;
                end
            end
            S_CHK1, S_CHK2: begin
                r_acc <= w_alu_res;
            end
            S_CHK3: begin
                if (r_hit) begin
                    // old message goes back unless the growth breaks the budget
                    if (!(w_grow && w_alu_neg)) begin
                        r_res_rmv <= 1'b1;
                        r_res_rm  <= r_hit_msg;
                    end
                end else if (!w_alu_neg && r_free && r_req_macq) begin
                    if (r_req_tacq) begin
                        r_res_ok <= 1'b1;
                    end else begin
                        // topic refused: hand the new message reference back
                        r_res_rmv <= 1'b1;
                        r_res_rm  <= r_req_msg;
                    end
                end
            end
            S_ADD: begin
                r_res_ok <= 1'b1;
            end
            S_IDXB: begin
                if (w_used[w_idx_addr]) begin
                    r_res_ok   <= 1'b1;
                    r_res_msg  <= w_rdata.msg;
                    r_res_slot <= w_rdata.slot;
                    r_res_gen  <= w_rdata.gen;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    r_o_ok    <= r_res_ok;
                    r_o_msg   <= r_res_msg;
                    r_o_slot  <= r_res_slot;
                    r_o_gen   <= r_res_gen;
                    r_o_rmv   <= r_res_rmv;
                    r_o_rm    <= r_res_rm;
                    r_o_rtv   <= r_res_rtv;
                    r_o_count <= r_count;
                    r_o_bytes <= r_total;
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    rmt_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata),
        .o_used  (w_used)
    );

    rmt_alu u_alu (
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .i_sub (w_alu_sub),
        .o_res (w_alu_res),
        .o_neg (w_alu_neg)
    );

    assign o_out_valid             = r_o_valid;
    assign o_ok                    = r_o_ok;
    assign o_out_message           = r_o_msg;
    assign o_out_topic_slot        = r_o_slot;
    assign o_out_topic_generation  = r_o_gen;
    assign o_release_message_valid = r_o_rmv;
    assign o_release_message       = r_o_rm;
    assign o_release_topic_valid   = r_o_rtv;
    assign o_entry_count           = r_o_count;
    assign o_bytes_in_use          = r_o_bytes;

endmodule

// ===== design/rmt_alu.sv =====
// shared add / subtract unit with sign of the difference
`timescale 1ns / 1ps

module rmt_alu (
    input  logic [rmt_pkg::ALU_W-1:0] i_a,
    input  logic [rmt_pkg::ALU_W-1:0] i_b,
    input  logic                      i_sub,
    output logic [rmt_pkg::ALU_W-1:0] o_res,
    output logic                      o_neg
);

    logic [rmt_pkg::ALU_W:0] w_full;

    always_comb begin
        if (i_sub) begin
            w_full = {1'b0, i_a} - {1'b0, i_b};
        end else begin
            w_full = {1'b0, i_a} + {1'b0, i_b};
        end
    end

    assign o_res = w_full[rmt_pkg::ALU_W-1:0];
    assign o_neg = w_full[rmt_pkg::ALU_W];

endmodule

// ===== design/rmt_store.sv =====
// entry memory with registered read port and per-entry used flags
`timescale 1ns / 1ps

module rmt_store #(
    parameter int ENTRIES = rmt_pkg::ENTRIES_DEF,
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rmt_pkg::t_wr_ctl      i_ctl,
    input  logic [AW-1:0]         i_waddr,
    input  rmt_pkg::t_entry       i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output rmt_pkg::t_entry       o_rdata,
    output logic [ENTRIES-1:0]    o_used
);

    rmt_pkg::t_entry     r_mem [ENTRIES];
    rmt_pkg::t_entry     r_rdata;
    logic [ENTRIES-1:0]  r_used;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_ctl.set_used) begin
            r_used[i_waddr] <= 1'b1;
        end else if (i_ctl.clr_used) begin
            r_used[i_waddr] <= 1'b0;
        end
    end

    assign o_rdata = r_rdata;
    assign o_used  = r_used;

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the retained message table
`timescale 1ns / 1ps

// directed commands cover the key extremes, every command and each put failure path;
// random traffic then runs over a small pool of topic keys so that puts in place,
// lookups and removes hit often and the table fills up, with a budget written for each
// of four handshake pressure phases and moved again in the last; every result transfer
// is checked field by field against a local model of the table

module testbench;
    import rmt_pkg::*;

    localparam int QUIET_LIMIT = 4000;  // cycles with no transfer before giving up
    localparam int DRAIN_WAIT  = 40;    // idle wait after the owed results are out
    localparam int KEY_POOL    = 24;    // more keys than entries, so the table can fill

    // one command as it goes into the table
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [SLOT_W-1:0] slot;
        logic [GEN_W-1:0]  gen;
        logic [MSG_W-1:0]  msg;
        logic [LEN_W-1:0]  len;
        logic              hvalid;
        logic              macq;
        logic              tacq;
        logic [IDX_W-1:0]  idx;
    } t_table_cmd;

    // one result as it comes out of the table
    typedef struct packed {
        logic               ok;
        logic [MSG_W-1:0]   message;
        logic [SLOT_W-1:0]  slot;
        logic [GEN_W-1:0]   gen;
        logic               rel_msg_valid;
        logic [MSG_W-1:0]   rel_msg;
        logic               rel_topic_valid;
        logic [COUNT_W-1:0] count;
        logic [BYTES_W-1:0] bytes;
    } t_table_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [BYTES_W-1:0]  i_cfg_byte_budget;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [CMD_W-1:0]    i_cmd;
    logic [SLOT_W-1:0]   i_topic_slot;
    logic [GEN_W-1:0]    i_topic_generation;
    logic [MSG_W-1:0]    i_message_handle;
    logic [LEN_W-1:0]    i_payload_len;
    logic                i_handles_valid;
    logic                i_msg_acquire_ok;
    logic                i_topic_acquire_ok;
    logic [IDX_W-1:0]    i_entry_index;
    logic                o_out_valid;
    logic                i_out_ready;
    logic                o_ok;
    logic [MSG_W-1:0]    o_out_message;
    logic [SLOT_W-1:0]   o_out_topic_slot;
    logic [GEN_W-1:0]    o_out_topic_generation;
    logic                o_release_message_valid;
    logic [MSG_W-1:0]    o_release_message;
    logic                o_release_topic_valid;
    logic [COUNT_W-1:0]  o_entry_count;
    logic [BYTES_W-1:0]  o_bytes_in_use;

    // local copy of the table contents and its byte accounting
    logic                tbl_used [ENTRIES_DEF];
    logic [SLOT_W-1:0]   tbl_slot [ENTRIES_DEF];
    logic [GEN_W-1:0]    tbl_gen  [ENTRIES_DEF];
    logic [MSG_W-1:0]    tbl_msg  [ENTRIES_DEF];
    logic [LEN_W-1:0]    tbl_len  [ENTRIES_DEF];
    logic [COUNT_W-1:0]  tbl_count;
    logic [BYTES_W-1:0]  tbl_bytes;
    logic [BYTES_W-1:0]  tbl_budget;

    // results still owed by the table, oldest first
    t_table_result       expected_q[$];

    // topic keys the random traffic draws from
    logic [SLOT_W-1:0]   key_slot [KEY_POOL];
    logic [GEN_W-1:0]    key_gen  [KEY_POOL];

    // handshake pressure, in percent of cycles
    int send_idle_pct  = 0;
    int out_stall_pct  = 0;

    int error_count     = 0;
    int results_checked = 0;
    int quiet_cycles    = 0;
    int put_sent        = 0;
    int get_sent        = 0;
    int remove_sent     = 0;
    int index_sent      = 0;
    int puts_stored     = 0;

    retained_message_table dut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cfg_valid             (i_cfg_valid),
        .o_cfg_ready             (o_cfg_ready),
        .i_cfg_byte_budget       (i_cfg_byte_budget),
        .i_in_valid              (i_in_valid),
        .o_in_ready              (o_in_ready),
        .i_cmd                   (i_cmd),
        .i_topic_slot            (i_topic_slot),
        .i_topic_generation      (i_topic_generation),
        .i_message_handle        (i_message_handle),
        .i_payload_len           (i_payload_len),
        .i_handles_valid         (i_handles_valid),
        .i_msg_acquire_ok        (i_msg_acquire_ok),
        .i_topic_acquire_ok      (i_topic_acquire_ok),
        .i_entry_index           (i_entry_index),
        .o_out_valid             (o_out_valid),
        .i_out_ready             (i_out_ready),
        .o_ok                    (o_ok),
        .o_out_message           (o_out_message),
        .o_out_topic_slot        (o_out_topic_slot),
        .o_out_topic_generation  (o_out_topic_generation),
        .o_release_message_valid (o_release_message_valid),
        .o_release_message       (o_release_message),
        .o_release_topic_valid   (o_release_topic_valid),
        .o_entry_count           (o_entry_count),
        .o_bytes_in_use          (o_bytes_in_use)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- table model

    function automatic int find_key(input logic [SLOT_W-1:0] slot,
                                    input logic [GEN_W-1:0] gen);
        for (int e = 0; e < ENTRIES_DEF; e++) begin
            if (tbl_used[e] && tbl_slot[e] == slot && tbl_gen[e] == gen)
                return e;
        end
        return -1;
    endfunction

    // byte total never goes below zero
    function automatic void drop_bytes(input logic [LEN_W-1:0] len);
        if (tbl_bytes >= BYTES_W'(len))
            tbl_bytes = tbl_bytes - BYTES_W'(len);
    endfunction

    // applies one command to the local table and returns the result it owes
    function automatic t_table_result predict_table(input t_table_cmd c);
        t_table_result r;
        int hit;
        int free_e;
        logic [LEN_W-1:0] old_len;
        logic [LEN_W-1:0] growth;
        logic             over;
        r = '0;
        hit = find_key(c.slot, c.gen);
        case (c.cmd)
            CMD_PUT: begin
                if (c.hvalid && hit >= 0) begin
                    // replace in place, unless the larger payload breaks the budget
                    old_len = tbl_len[hit];
                    growth  = c.len - old_len;
                    over    = (c.len > old_len) &&
                              (ALU_W'(tbl_bytes) + ALU_W'(growth) > ALU_W'(tbl_budget));
                    if (!over) begin
                        r.rel_msg_valid = 1'b1;
                        r.rel_msg       = tbl_msg[hit];
                        if (!c.macq) begin
                            // refused acquire drops the entry and its old length
                            tbl_used[hit] = 1'b0;
                            if (tbl_count > 0)
                                tbl_count = tbl_count - 1'b1;
                            drop_bytes(old_len);
                        end else begin
                            tbl_msg[hit] = c.msg;
                            tbl_len[hit] = c.len;
                            drop_bytes(old_len);
                            tbl_bytes = tbl_bytes + BYTES_W'(c.len);
                            r.ok = 1'b1;
                        end
                    end
                end else if (c.hvalid &&
                             ALU_W'(tbl_bytes) + ALU_W'(c.len) <= ALU_W'(tbl_budget)) begin
                    free_e = -1;
                    for (int e = ENTRIES_DEF - 1; e >= 0; e--) begin
                        if (!tbl_used[e])
                            free_e = e;
                    end
                    if (free_e >= 0 && c.macq) begin
                        if (!c.tacq) begin
                            // topic refused: the freshly granted message goes back
                            r.rel_msg_valid = 1'b1;
                            r.rel_msg       = c.msg;
                        end else begin
                            tbl_used[free_e] = 1'b1;
                            tbl_slot[free_e] = c.slot;
                            tbl_gen[free_e]  = c.gen;
                            tbl_msg[free_e]  = c.msg;
                            tbl_len[free_e]  = c.len;
                            if (tbl_count < COUNT_MAX)
                                tbl_count = tbl_count + 1'b1;
                            tbl_bytes = tbl_bytes + BYTES_W'(c.len);
                            r.ok = 1'b1;
                        end
                    end
                end
            end
            CMD_GET: begin
                if (hit >= 0) begin
                    r.ok      = 1'b1;
                    r.message = tbl_msg[hit];
                end
            end
            CMD_REMOVE: begin
                if (hit >= 0) begin
                    r.ok              = 1'b1;
                    r.rel_msg_valid   = 1'b1;
                    r.rel_msg         = tbl_msg[hit];
                    r.rel_topic_valid = 1'b1;
                    tbl_used[hit]     = 1'b0;
                    if (tbl_count > 0)
                        tbl_count = tbl_count - 1'b1;
                    drop_bytes(tbl_len[hit]);
                end
            end
            CMD_INDEX: begin
                if (int'(c.idx) < ENTRIES_DEF && tbl_used[c.idx]) begin
                    r.ok      = 1'b1;
                    r.message = tbl_msg[c.idx];
                    r.slot    = tbl_slot[c.idx];
                    r.gen     = tbl_gen[c.idx];
                end
            end
            default: ;
        endcase
        r.count = tbl_count;
        r.bytes = tbl_bytes;
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic t_table_cmd put_cmd(input logic [SLOT_W-1:0] slot,
                                           input logic [GEN_W-1:0] gen,
                                           input logic [MSG_W-1:0] msg,
                                           input logic [LEN_W-1:0] len,
                                           input logic hvalid, input logic macq,
                                           input logic tacq);
        t_table_cmd c;
        c = '0;
        c.cmd    = CMD_PUT;
        c.slot   = slot;
        c.gen    = gen;
        c.msg    = msg;
        c.len    = len;
        c.hvalid = hvalid;
        c.macq   = macq;
        c.tacq   = tacq;
        return c;
    endfunction

    function automatic t_table_cmd key_cmd(input logic [CMD_W-1:0] cmd,
                                           input logic [SLOT_W-1:0] slot,
                                           input logic [GEN_W-1:0] gen);
        t_table_cmd c;
        c = '0;
        c.cmd  = cmd;
        c.slot = slot;
        c.gen  = gen;
        return c;
    endfunction

    function automatic t_table_cmd index_cmd(input logic [IDX_W-1:0] idx);
        t_table_cmd c;
        c = '0;
        c.cmd = CMD_INDEX;
        c.idx = idx;
        return c;
    endfunction

    // mostly keys from the pool, mostly granted puts, mostly short payloads
    function automatic t_table_cmd random_cmd();
        t_table_cmd c;
        int pick;
        int k;
        pick = $urandom_range(99);
        if (pick < 45)
            c.cmd = CMD_PUT;
        else if (pick < 65)
            c.cmd = CMD_GET;
        else if (pick < 85)
            c.cmd = CMD_REMOVE;
        else
            c.cmd = CMD_INDEX;
        k = $urandom_range(KEY_POOL - 1);
        if ($urandom_range(99) < 85) begin
            c.slot = key_slot[k];
            c.gen  = key_gen[k];
        end else begin
            c.slot = SLOT_W'($urandom);
            c.gen  = GEN_W'($urandom);
        end
        c.msg = MSG_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 70)
            c.len = LEN_W'($urandom_range(2047));
        else if (pick < 90)
            c.len = LEN_W'($urandom);
        else if (pick < 95)
            c.len = '0;
        else
            c.len = '1;
        c.hvalid = ($urandom_range(99) < 92);
        c.macq   = ($urandom_range(99) < 90);
        c.tacq   = ($urandom_range(99) < 90);
        c.idx    = IDX_W'($urandom);
        return c;
    endfunction

    // one command transfer; valid stays high after the transfer so that a
    // back-to-back command needs no second assignment in the same step
    task automatic send_cmd(input t_table_cmd c);
        t_table_result r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_cmd              <= c.cmd;
        i_topic_slot       <= c.slot;
        i_topic_generation <= c.gen;
        i_message_handle   <= c.msg;
        i_payload_len      <= c.len;
        i_handles_valid    <= c.hvalid;
        i_msg_acquire_ok   <= c.macq;
        i_topic_acquire_ok <= c.tacq;
        i_entry_index      <= c.idx;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        r = predict_table(c);
        expected_q.push_back(r);
        case (c.cmd)
            CMD_PUT: begin
                put_sent++;
                if (r.ok)
                    puts_stored++;
            end
            CMD_GET:    get_sent++;
            CMD_REMOVE: remove_sent++;
            default:    index_sent++;
        endcase
    endtask

    // drop valid and wait for every owed result to come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
    endtask

    // budget writes only while the table is idle
    task automatic write_budget(input logic [BYTES_W-1:0] value);
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_valid       <= 1'b1;
        i_cfg_byte_budget <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        tbl_budget = value;
    endtask

    // ---------------------------------------------------------------- tests

    // key extremes, put new, put in place, get and index reads
    task automatic test_put_and_lookup();
        send_cmd(key_cmd(CMD_GET, 8'h00, 16'h0000));                    // empty table miss
        send_cmd(put_cmd(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 1)); // largest key and length
        send_cmd(put_cmd(8'h00, 16'h0000, 16'h00AA, 16'd1, 1, 1, 1));    // fills budget exactly
        send_cmd(put_cmd(8'hFF, 16'hFFFF, 16'h1234, 16'hFFFF, 1, 1, 1)); // in place, same length
        send_cmd(key_cmd(CMD_GET, 8'hFF, 16'hFFFF));
        send_cmd(index_cmd(4'd0));
        send_cmd(index_cmd(4'd1));
        send_cmd(index_cmd(4'd15));                                      // unused entry
    endtask

    // each way a put can be refused
    task automatic test_put_refusals();
        send_cmd(put_cmd(8'h05, 16'h0005, 16'h0777, 16'd3, 0, 1, 1));    // invalid handles
        send_cmd(put_cmd(8'h11, 16'h2222, 16'h0001, 16'd2, 1, 1, 1));    // new entry over budget
        send_cmd(put_cmd(8'h00, 16'h0000, 16'h0005, 16'd2, 1, 1, 1));    // in place growth over
        send_cmd(put_cmd(8'hFF, 16'hFFFF, 16'h4321, 16'd0, 1, 0, 1));    // in place, acquire refused
        send_cmd(put_cmd(8'h11, 16'h2222, 16'h0042, 16'd1, 1, 1, 0));    // new, topic refused
        send_cmd(put_cmd(8'h11, 16'h2222, 16'h0043, 16'd1, 1, 0, 1));    // new, message refused
        send_cmd(key_cmd(CMD_GET, 8'hFF, 16'hFFFF));                     // freed by the refusal
    endtask

    // remove of a present and of an absent topic
    task automatic test_remove();
        send_cmd(key_cmd(CMD_REMOVE, 8'h00, 16'h0000));
        send_cmd(key_cmd(CMD_REMOVE, 8'h00, 16'h0000));
    endtask

    // zero budget still takes empty payloads, all-ones budget takes anything
    task automatic test_budget_extremes();
        write_budget('0);
        send_cmd(put_cmd(8'h07, 16'h8000, 16'h0000, 16'd0, 1, 1, 1));
        send_cmd(put_cmd(8'h09, 16'h0001, 16'h0101, 16'd1, 1, 1, 1));
        send_cmd(put_cmd(8'h07, 16'h8000, 16'h0102, 16'd1, 1, 1, 1));
        write_budget('1);
        send_cmd(put_cmd(8'h09, 16'h0001, 16'hFFFF, 16'hFFFF, 1, 1, 1));
        send_cmd(index_cmd(4'd0));
        send_cmd(key_cmd(CMD_REMOVE, 8'h07, 16'h8000));
        send_cmd(key_cmd(CMD_REMOVE, 8'h09, 16'h0001));
    endtask

    // random traffic in four pressure phases, each starting under its own budget
    task automatic test_random_traffic();
        key_slot[0] = '0;
        key_gen[0]  = '0;
        key_slot[1] = '1;
        key_gen[1]  = '1;
        for (int k = 2; k < KEY_POOL; k++) begin
            key_slot[k] = SLOT_W'($urandom);
            key_gen[k]  = GEN_W'($urandom);
        end
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_budget(BUDGET_RESET);
                1: write_budget(32'd20000);
                2: write_budget('1);
                default: write_budget(BYTES_W'($urandom_range(300000)));
            endcase
            send_idle_pct = (phase == 1) ? 46 : (phase == 3) ? 8 : 0;
            out_stall_pct = (phase == 2) ? 46 : (phase == 3) ? 8 : 0;
            for (int n = 0; n < 175; n++) begin
                // last phase keeps moving the budget under a loaded table
                if (phase == 3 && n % 35 == 34)
                    write_budget(BYTES_W'($urandom_range(300000)));
                send_cmd(random_cmd());
            end
        end
    endtask

    // ---------------------------------------------------------------- result checking

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_table_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: result transfer with nothing expected", $time);
                error_count++;
            end else begin
                want = expected_q.pop_front();
                results_checked++;
                check_field("ok", want.ok, o_ok);
                check_field("out_message", want.message, o_out_message);
                check_field("out_topic_slot", want.slot, o_out_topic_slot);
                check_field("out_topic_generation", want.gen, o_out_topic_generation);
                check_field("release_message_valid", want.rel_msg_valid,
                            o_release_message_valid);
                check_field("release_message", want.rel_msg, o_release_message);
                check_field("release_topic_valid", want.rel_topic_valid,
                            o_release_topic_valid);
                check_field("entry_count", want.count, o_entry_count);
                check_field("bytes_in_use", want.bytes, o_bytes_in_use);
            end
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, QUIET_LIMIT, expected_q.size());
        $display("testbench: errors");
        $finish;
    end

    // ---------------------------------------------------------------- main sequence

    initial begin
        i_rst_n            <= 1'b0;
        i_cfg_valid        <= 1'b0;
        i_cfg_byte_budget  <= '0;
        i_in_valid         <= 1'b0;
        i_cmd              <= CMD_PUT;
        i_topic_slot       <= '0;
        i_topic_generation <= '0;
        i_message_handle   <= '0;
        i_payload_len      <= '0;
        i_handles_valid    <= 1'b0;
        i_msg_acquire_ok   <= 1'b0;
        i_topic_acquire_ok <= 1'b0;
        i_entry_index      <= '0;
        i_out_ready        <= 1'b1;
        for (int e = 0; e < ENTRIES_DEF; e++) begin
            tbl_used[e] = 1'b0;
            tbl_slot[e] = '0;
            tbl_gen[e]  = '0;
            tbl_msg[e]  = '0;
            tbl_len[e]  = '0;
        end
        tbl_count  = '0;
        tbl_bytes  = '0;
        tbl_budget = BUDGET_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_put_and_lookup();
        test_put_refusals();
        test_remove();
        test_budget_extremes();
        test_random_traffic();

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (expected_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_q.size());
            error_count++;
        end
        $display("summary: %0d commands (%0d put, %0d get, %0d remove, %0d index read)",
                 put_sent + get_sent + remove_sent + index_sent,
                 put_sent, get_sent, remove_sent, index_sent);
        $display("summary: %0d results checked, %0d puts stored, budgets zero to all ones",
                 results_checked, puts_stored);
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/rmt_pkg.sv
design/rmt_alu.sv
design/rmt_store.sv
design/retained_message_table.sv
tb/sv/testbench.sv
